/* rtl/spu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spu_pkg
// Types, widths and codes shared by the screen point unprojection block.
// ----------------------------------------------------------------------------
package spu_pkg;

  // NDC coordinate, Q.16, signed
  localparam int NDC_W   = 35;
  // row product sum at scale 2^(16+matrix fraction bits)
  localparam int SUM_W   = 52;
  // product of one matrix entry and one NDC coordinate
  localparam int PROD_W  = 51;
  // near point coordinate, Q.16, magnitude capped below 2^62
  localparam int PT_W    = 63;
  // shared divider in the back end
  localparam int DIV_NW  = SUM_W + 16;
  localparam int DIV_DW  = SUM_W;
  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NEAR_W   = 2'd1;
  localparam logic [1:0] ST_FAR_W    = 2'd2;
  localparam logic [1:0] ST_ZERO_DIR = 2'd3;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ROW0   = 3'd2;
  localparam logic [2:0] REG_ROW1   = 3'd3;
  localparam logic [2:0] REG_ROW2   = 3'd4;
  localparam logic [2:0] REG_ROW3   = 3'd5;

  typedef logic [3:0][63:0] mat_t;

  typedef struct packed {
    logic signed [NDC_W-1:0] xq;
    logic signed [NDC_W-1:0] yq;
  } ndc_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [1:0]         ray_status;
  } result_t;

  typedef enum logic [1:0] {F_IDLE, F_DIVX, F_DIVY, F_PUSH} front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_MUL, B_CHKN, B_DIVN, B_CHKF, B_DIVF, B_NORM, B_SQ, B_SQRT, B_DIR, B_DONE
  } back_state_t;

  function automatic logic signed [15:0] entry_of(input logic [63:0] row,
                                                  input logic [1:0] col);
    return row[{col, 4'b0000} +: 16];
  endfunction

  // entry times 2^16, at the width of a row sum
  function automatic logic signed [SUM_W-1:0] shift16(input logic signed [15:0] e);
    return {{(SUM_W-32){e[15]}}, e, 16'h0000};
  endfunction

endpackage
`default_nettype wire

/* rtl/spu_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spu_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spu_div #(
  parameter int N_W = 33,
  parameter int D_W = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic           done,
  output logic [N_W-1:0] quo
);
  localparam int CNT_W = $clog2(N_W + 1);

  logic [D_W:0]   rem;
  logic [D_W:0]   rem_sh;
  logic [D_W:0]   rem_sub;
  logic [N_W-1:0] qsh;
  logic [D_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic           run;
  logic           ge;

  assign rem_sh  = {rem[D_W-1:0], qsh[N_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign quo     = qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(N_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qsh   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (run) begin
      rem <= ge ? rem_sub : rem_sh;
      qsh <= {qsh[N_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

/* rtl/spu_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spu_front
// Takes pixel transactions and maps them to NDC x and y in Q.16.
// ----------------------------------------------------------------------------
module spu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [15:0]   pixel_x,
  input  logic [15:0]   pixel_y,
  input  logic [15:0]   w_eff,
  input  logic [15:0]   h_eff,
  output logic          q_valid,
  input  logic          q_ready,
  output spu_pkg::ndc_t q_data
);
  import spu_pkg::*;

  front_state_t state, state_next;

  logic        hold_valid;
  logic [15:0] hold_px, hold_py;
  logic [15:0] work_px, work_py;
  logic signed [NDC_W-1:0] xq;

  logic signed [17:0] sx, sy;
  logic [16:0] mx, my;
  logic        div_start, div_done;
  logic [32:0] div_num, div_quo;
  logic [15:0] div_den;
  logic signed [17:0] sx_work;

  // 2px - w from the held pixel, h - 2py from the working pixel
  assign sx      = $signed({1'b0, hold_px, 1'b0}) - $signed({2'b00, w_eff});
  assign sy      = $signed({2'b00, h_eff}) - $signed({1'b0, work_py, 1'b0});
  assign sx_work = $signed({1'b0, work_px, 1'b0}) - $signed({2'b00, w_eff});
  assign mx      = sx[17] ? 17'(-sx) : sx[16:0];
  assign my      = sy[17] ? 17'(-sy) : sy[16:0];

  assign in_ready = !hold_valid;

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (hold_valid) state_next = F_DIVX;
      F_DIVX: if (div_done) state_next = F_DIVY;
      F_DIVY: if (div_done) state_next = F_PUSH;
      F_PUSH: if (q_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = {my, 16'h0000};
    div_den   = h_eff;
    q_valid   = 1'b0;
    case (state)
      F_IDLE: begin
        div_start = hold_valid;
        div_num   = {mx, 16'h0000};
        div_den   = w_eff;
      end
      F_DIVX: div_start = div_done;
      F_DIVY: ;
      F_PUSH: q_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      hold_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        hold_valid <= 1'b1;
      end else if (state == F_IDLE) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_px <= pixel_x;
      hold_py <= pixel_y;
    end
    if (state == F_IDLE && hold_valid) begin
      work_px <= hold_px;
      work_py <= hold_py;
    end
    if (state == F_DIVX && div_done) begin
      xq <= sx_work[17] ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    end
    if (state == F_DIVY && div_done) begin
      q_data.xq <= xq;
      q_data.yq <= sy[17] ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    end
  end

  spu_div #(.N_W(33), .D_W(16)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule
`default_nettype wire

/* rtl/spu_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spu_fifo
// Short queue of NDC pairs between front and back.
// ----------------------------------------------------------------------------
module spu_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  spu_pkg::ndc_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output spu_pkg::ndc_t out_data
);
  import spu_pkg::*;

  ndc_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push, pop;

  assign in_ready  = count != (QPTR_W+1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

endmodule
`default_nettype wire

/* rtl/spu_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spu_back
// Sequencer: matrix rows, perspective divides, normalisation, square root
// and direction divides, through two multipliers and one shared divider.
// ----------------------------------------------------------------------------
module spu_back #(
  parameter int DIR_FRAC = 14
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  spu_pkg::ndc_t   q_data,
  input  spu_pkg::mat_t   matrix,
  output logic            out_valid,
  input  logic            out_ready,
  output spu_pkg::result_t out_data
);
  import spu_pkg::*;

  back_state_t state, state_next;

  logic signed [NDC_W-1:0]  xq, yq;
  logic [3:0]               mcnt;
  logic [1:0]               idx;
  logic [4:0]               sqcnt;
  logic                     div_run;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;
  logic signed [SUM_W-1:0]  base [4];
  logic signed [PT_W-1:0]   np [3];
  logic [PT_W-1:0]          m [3];
  logic                     neg [3];
  logic signed [15:0]       dir [3];
  logic [1:0]               status;
  logic [59:0]              prod2;
  logic [61:0]              s;
  logic [PT_W-1:0]          res, bitr;

  logic signed [15:0]       e_mul;
  logic signed [PROD_W-1:0] e_ext, op_ext, mul_res;
  logic signed [SUM_W-1:0]  prod_ext;
  logic                     far;
  logic signed [SUM_W-1:0]  n_sel, d_sel;
  logic [SUM_W-1:0]         n_mag, d_mag;
  logic [PT_W-1:0]          m_cur, big;
  logic [59:0]              sq_res;
  logic [PT_W:0]            tmp;
  logic                     div_start, div_done;
  logic [DIV_NW-1:0]        div_num, div_quo;
  logic [DIV_DW-1:0]        div_den;
  logic [61:0]              pt_mag;
  logic signed [PT_W-1:0]   pt_val;
  logic signed [PT_W:0]     diff;
  logic [15:0]              dq;

  function automatic logic signed [31:0] sat32(input logic signed [PT_W-1:0] v);
    if (!v[PT_W-1] && (|v[PT_W-2:31])) return 32'sh7FFFFFFF;
    if (v[PT_W-1] && !(&v[PT_W-2:31])) return 32'sh80000000;
    return v[31:0];
  endfunction

  // multiplier operands: even steps take x, odd steps take y
  assign e_mul    = entry_of(matrix[mcnt[2:1]], {1'b0, mcnt[0]});
  assign e_ext    = {{(PROD_W-16){e_mul[15]}}, e_mul};
  assign op_ext   = mcnt[0] ? {{(PROD_W-NDC_W){yq[NDC_W-1]}}, yq}
                            : {{(PROD_W-NDC_W){xq[NDC_W-1]}}, xq};
  assign mul_res  = e_ext * op_ext;
  assign prod_ext = {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};

  assign far   = (state == B_CHKF) || (state == B_DIVF);
  assign n_sel = base[idx] + (far ? shift16(entry_of(matrix[idx], 2'd2)) : '0);
  assign d_sel = base[3] + (far ? shift16(entry_of(matrix[3], 2'd2)) : '0);
  assign n_mag = n_sel[SUM_W-1] ? SUM_W'(-n_sel) : n_sel;
  assign d_mag = d_sel[SUM_W-1] ? SUM_W'(-d_sel) : d_sel;

  assign m_cur  = m[idx];
  assign big    = (m[0] > m[1]) ? ((m[0] > m[2]) ? m[0] : m[2])
                                : ((m[1] > m[2]) ? m[1] : m[2]);
  assign sq_res = m_cur[29:0] * m_cur[29:0];
  assign tmp    = {1'b0, res} + {1'b0, bitr};

  // capped point quotient and its difference to the near point
  assign pt_mag = (|div_quo[DIV_NW-1:62]) ? '1 : div_quo[61:0];
  assign pt_val = (n_sel[SUM_W-1] ^ d_sel[SUM_W-1]) ? -$signed({1'b0, pt_mag})
                                                    : $signed({1'b0, pt_mag});
  assign diff   = {pt_val[PT_W-1], pt_val} - {np[idx][PT_W-1], np[idx]};
  assign dq     = div_quo[15:0];

  always_comb begin
    if (state == B_DIR) begin
      div_num = DIV_NW'(m_cur[29:0]) << DIR_FRAC;
      div_den = DIV_DW'(res[30:0]);
    end else begin
      div_num = {n_mag, 16'h0000};
      div_den = d_mag;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (q_valid) state_next = B_MUL;
      B_MUL:  if (mcnt == 4'd8) state_next = B_CHKN;
      B_CHKN: state_next = (base[3] == '0) ? B_DONE : B_DIVN;
      B_DIVN: if (div_done && idx == 2'd2) state_next = B_CHKF;
      B_CHKF: state_next = (d_sel == '0) ? B_DONE : B_DIVF;
      B_DIVF: if (div_done && idx == 2'd2) state_next = B_NORM;
      B_NORM: begin
        if (big == '0) state_next = B_DONE;
        else if (!(|big[PT_W-1:30]) && (|big[29])) state_next = B_SQ;
      end
      B_SQ:   if (mcnt == 4'd3) state_next = B_SQRT;
      B_SQRT: if (sqcnt == 5'd31) state_next = B_DIR;
      B_DIR:  if (div_done && idx == 2'd2) state_next = B_DONE;
      B_DONE: if (!out_valid || out_ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = 1'b0;
    div_start = 1'b0;
    case (state)
      B_IDLE: q_ready = 1'b1;
      B_DIVN, B_DIVF, B_DIR: div_start = !div_run;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      div_run   <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (state == B_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (div_start) div_run <= 1'b1;
      else if (div_done) div_run <= 1'b0;
      if ((state == B_DIVN || state == B_DIVF || state == B_DIR) && div_done) begin
        idx <= (idx == 2'd2) ? 2'd0 : idx + 1'b1;
      end else if (state == B_SQ && mcnt != 4'd3) begin
        idx <= (idx == 2'd2) ? 2'd0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        xq     <= q_data.xq;
        yq     <= q_data.yq;
        mcnt   <= '0;
        status <= ST_OK;
      end
      B_MUL: begin
        mcnt <= mcnt + 1'b1;
        if (mcnt != 4'd8) prod <= mul_res;
        if (mcnt[0]) begin
          acc <= prod_ext + shift16(entry_of(matrix[mcnt[2:1]], 2'd3));
        end else if (mcnt != 4'd0) begin
          // row finished: shift it in, row 0 ends at the bottom
          base[0] <= base[1];
          base[1] <= base[2];
          base[2] <= base[3];
          base[3] <= acc + prod_ext;
        end
      end
      B_CHKN: if (base[3] == '0) status <= ST_NEAR_W;
      B_DIVN: if (div_done) np[idx] <= pt_val;
      B_CHKF: if (d_sel == '0) status <= ST_FAR_W;
      B_DIVF: begin
        if (div_done) begin
          m[idx]   <= diff[PT_W] ? PT_W'(-diff) : diff[PT_W-1:0];
          neg[idx] <= diff[PT_W];
        end
      end
      B_NORM: begin
        mcnt <= '0;
        s    <= '0;
        if (big == '0) begin
          status <= ST_ZERO_DIR;
        end else if (|big[PT_W-1:30]) begin
          for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
        end else if (!(|big[29])) begin
          for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
        end
      end
      B_SQ: begin
        mcnt <= mcnt + 1'b1;
        if (mcnt != 4'd3) prod2 <= sq_res;
        if (mcnt != 4'd0) s <= s + 62'(prod2);
        res   <= '0;
        bitr  <= PT_W'(1) << 62;
        sqcnt <= '0;
      end
      B_SQRT: begin
        sqcnt <= sqcnt + 1'b1;
        bitr  <= bitr >> 2;
        if ({2'b00, s} >= tmp) begin
          s   <= s - tmp[61:0];
          res <= (res >> 1) + bitr;
        end else begin
          res <= res >> 1;
        end
      end
      B_DIR: if (div_done) dir[idx] <= neg[idx] ? -$signed(dq) : $signed(dq);
      B_DONE: begin
        if (!out_valid || out_ready) begin
          out_data.origin_x   <= (status == ST_NEAR_W) ? '0 : sat32(np[0]);
          out_data.origin_y   <= (status == ST_NEAR_W) ? '0 : sat32(np[1]);
          out_data.origin_z   <= (status == ST_NEAR_W) ? '0 : sat32(np[2]);
          out_data.dir_x      <= (status == ST_OK) ? dir[0] : '0;
          out_data.dir_y      <= (status == ST_OK) ? dir[1] : '0;
          out_data.dir_z      <= (status == ST_OK) ? dir[2] : '0;
          out_data.ray_status <= status;
        end
      end
      default: ;
    endcase
  end

  spu_div #(.N_W(DIV_NW), .D_W(DIV_DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule
`default_nettype wire

/* rtl/screen_point_unproject_ray.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// screen_point_unproject_ray
// Pixel position to world picking ray through an inverse view-projection.
//
//   channel  direction  transfer on           content
//   s_*      in         s_tvalid & s_tready   pixel_x, pixel_y
//   m_*      out        m_tvalid & m_tready   origin xyz, direction xyz, status
//   cfg_*    in         cfg_we                width, height, matrix rows 0..3
//
// Front: two 33-bit bit-serial divides per pixel for NDC.
// Back: one 68-bit bit-serial divider for six perspective divides and three
// direction divides, plus normalisation and square root. Less work on a zero w.
// Front, queue (four entries) and output register stall independently.
// Reset is synchronous; it empties the pipe and restores the register defaults.
// ----------------------------------------------------------------------------
module screen_point_unproject_ray #(
  parameter int DIR_FRAC = 14
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // pixel_x, pixel_y
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  output logic [1:0]   m_tuser,   // ray_status
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import spu_pkg::*;

  logic [15:0] image_width, image_height;
  logic [15:0] w_eff, h_eff;
  mat_t        matrix;
  logic        fq_valid, fq_ready, bq_valid, bq_ready;
  ndc_t        fq_data, bq_data;
  result_t     res;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 16'd1;
      image_height <= 16'd1;
      matrix       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[15:0];
        REG_HEIGHT: image_height <= cfg_data[15:0];
        REG_ROW0:   matrix[0]    <= cfg_data;
        REG_ROW1:   matrix[1]    <= cfg_data;
        REG_ROW2:   matrix[2]    <= cfg_data;
        REG_ROW3:   matrix[3]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // a zero size counts as one pixel
  assign w_eff = (image_width == '0) ? 16'd1 : image_width;
  assign h_eff = (image_height == '0) ? 16'd1 : image_height;

  spu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .pixel_x  (s_tdata[15:0]),
    .pixel_y  (s_tdata[31:16]),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  spu_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (bq_valid),
    .out_ready (bq_ready),
    .out_data  (bq_data)
  );

  spu_back #(.DIR_FRAC(DIR_FRAC)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (bq_valid),
    .q_ready   (bq_ready),
    .q_data    (bq_data),
    .matrix    (matrix),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = {res.dir_z, res.dir_y, res.dir_x,
                    res.origin_z, res.origin_y, res.origin_x};
  assign m_tuser = res.ray_status;

endmodule
`default_nettype wire
